@@ src/float32_truncating_adder_macros.svh @@
// assertion macros for the truncating adder checker
`ifndef FLOAT32_TRUNCATING_ADDER_MACROS_SVH
`define FLOAT32_TRUNCATING_ADDER_MACROS_SVH

// implication checked on every clock edge outside reset
`define FTA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fta_pkg.sv @@
// ----------------------------------------------------------------------------
// fta_pkg
// Shared widths and constants for the truncating single-precision adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fta_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned MagW  = 24;
  localparam int unsigned ExpW  = 8;
  // signed internal exponent wide enough for -127-24 .. 129
  localparam int unsigned SExpW = 10;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;
endpackage
`default_nettype wire

@@ src/fta_in_if.sv @@
// ----------------------------------------------------------------------------
// fta_in_if
// Operand channel: valid/ready with two single-precision bit patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface fta_in_if;
  logic                          valid;
  logic                          ready;
  logic [fta_pkg::WordW-1:0]     a_bits;
  logic [fta_pkg::WordW-1:0]     b_bits;
  modport source (output valid, a_bits, b_bits, input ready);
  modport sink   (input valid, a_bits, b_bits, output ready);
endinterface
`default_nettype wire

@@ src/fta_out_if.sv @@
// ----------------------------------------------------------------------------
// fta_out_if
// Result channel: valid/ready with the sum pattern and range flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface fta_out_if;
  logic                          valid;
  logic                          ready;
  logic [fta_pkg::WordW-1:0]     sum_bits;
  logic                          range_error;
  modport source (output valid, sum_bits, range_error, input ready);
  modport sink   (input valid, sum_bits, range_error, output ready);
endinterface
`default_nettype wire

@@ src/float32_truncating_adder.sv @@
// ----------------------------------------------------------------------------
// float32_truncating_adder
// Truncating single-precision adder with a one-bit-per-cycle shifter.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in      | in  | a_bits, b_bits
// out     | out | sum_bits, range_error
//
// a word steps through IDLE, ALIGN (one shift per alignment step, up to 24),
// ADD, NORM (one shift per normalization step, up to 23) and DONE; a long
// alignment leaves almost nothing for normalization to cancel.
// in.ready is high only while the sequencer is idle; a finished word waits in
// the output register until taken. synchronous reset clears the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module float32_truncating_adder (
  input  wire logic clk,
  input  wire logic rst,
  fta_in_if.sink    in,
  fta_out_if.source out
);
  localparam int unsigned MagW  = fta_pkg::MagW;
  localparam int unsigned SExpW = fta_pkg::SExpW;

  typedef enum logic [2:0] {IDLE, ALIGN, ADD, NORM, DONE} state_t;
  state_t state;

  logic [MagW-1:0]  big, lesser;     // big keeps the larger-exponent operand
  logic             big_neg, lesser_neg;
  logic [SExpW-1:0] diff, expo;
  logic [MagW-1:0]  guard;           // only the latest 24 dropped bits matter
  logic [MagW:0]    mag;
  logic             neg;

  logic [MagW-1:0]  ma, mb;
  logic [SExpW-1:0] ea, eb;
  logic [MagW+1:0]  sa, sb, ssum;
  logic [SExpW-1:0] biased;

  always_comb begin
    ma = {1'b1, in.a_bits[22:0]};
    mb = {1'b1, in.b_bits[22:0]};
    ea = SExpW'(in.a_bits[30:23]);
    eb = SExpW'(in.b_bits[30:23]);
    sa = big_neg ? -{2'b00, big} : {2'b00, big};
    sb = lesser_neg ? -{2'b00, lesser} : {2'b00, lesser};
    ssum = sa + sb;
    biased = expo + SExpW'(fta_pkg::ExpBias);
  end

  assign in.ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready && state != DONE) out.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in.valid) begin
            guard <= '0;
            if (ea > eb) begin
              big <= ma; big_neg <= in.a_bits[31];
              lesser <= mb; lesser_neg <= in.b_bits[31];
              diff <= ea - eb; expo <= ea - SExpW'(fta_pkg::ExpBias);
            end else begin
              big <= mb; big_neg <= in.b_bits[31];
              lesser <= ma; lesser_neg <= in.a_bits[31];
              diff <= eb - ea; expo <= eb - SExpW'(fta_pkg::ExpBias);
            end
            state <= ALIGN;
          end
        end
        ALIGN: begin
          if (diff == '0 || lesser == '0) begin
            state <= ADD;
          end else begin
            guard <= {guard[MagW-2:0], lesser[0]};
            lesser <= lesser >> 1;
            diff <= diff - SExpW'(1);
          end
        end
        ADD: begin
          neg <= ssum[MagW+1];
          mag <= ssum[MagW+1] ? (MagW+1)'(0) - ssum[MagW:0] : ssum[MagW:0];
          state <= NORM;
        end
        NORM: begin
          if (mag[MagW]) begin
            mag <= mag >> 1;
            expo <= expo + SExpW'(1);
            state <= DONE;
          end else if (mag[MagW-1] || mag == '0) begin
            state <= DONE;
          end else begin
            mag <= {mag[MagW-1:0], guard[0]};
            guard <= guard >> 1;
            expo <= expo - SExpW'(1);
          end
        end
        DONE: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            if (mag == '0) begin
              out.sum_bits <= '0;
              out.range_error <= 1'b0;
            end else begin
              out.sum_bits <= {neg, biased[7:0], mag[22:0]};
              out.range_error <= biased[SExpW-1] || biased == '0 || biased > 10'd254;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/fta_checker.sv @@
// ----------------------------------------------------------------------------
// fta_checker
// Port-level checks on the truncating adder, bound into float32_truncating_adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "float32_truncating_adder_macros.svh"
module fta_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] sum_bits,
  input wire logic range_error
);
  `FTA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `FTA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sum_bits), "output dropped")
  `FTA_ASSERT_IMPL(a_wrap_flag, clk, rst, out_valid && sum_bits[30:23] == 8'hff, range_error, "exponent 255 unflagged")
endmodule

bind float32_truncating_adder fta_checker u_fta_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .sum_bits(out.sum_bits), .range_error(out.range_error)
);
`default_nettype wire
